// ===== src/mdp_pkg.sv =====
// Types and constants shared by the metadata descriptor parser files.
package mdp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [15:0] {
    PH_APPFMT  = 16'b0000_0000_0000_0001,
    PH_APPID   = 16'b0000_0000_0000_0010,
    PH_FMT     = 16'b0000_0000_0000_0100,
    PH_FMTID   = 16'b0000_0000_0000_1000,
    PH_SVCID   = 16'b0000_0000_0001_0000,
    PH_FLAGS   = 16'b0000_0000_0010_0000,
    PH_SVCLEN  = 16'b0000_0000_0100_0000,
    PH_SVCBYTE = 16'b0000_0000_1000_0000,
    PH_CFGLEN  = 16'b0000_0001_0000_0000,
    PH_CFGBYTE = 16'b0000_0010_0000_0000,
    PH_CIDLEN  = 16'b0000_0100_0000_0000,
    PH_CIDBYTE = 16'b0000_1000_0000_0000,
    PH_CFGSVC  = 16'b0001_0000_0000_0000,
    PH_RESLEN  = 16'b0010_0000_0000_0000,
    PH_RESBYTE = 16'b0100_0000_0000_0000,
    PH_PRIVATE = 16'b1000_0000_0000_0000
  } phase_t;

  // Field tags on the result channel.
  localparam logic [3:0] TAG_APP_FMT   = 4'd0;
  localparam logic [3:0] TAG_APP_ID    = 4'd1;
  localparam logic [3:0] TAG_FMT       = 4'd2;
  localparam logic [3:0] TAG_FMT_ID    = 4'd3;
  localparam logic [3:0] TAG_SVC_ID    = 4'd4;
  localparam logic [3:0] TAG_FLAGS     = 4'd5;
  localparam logic [3:0] TAG_SVC_LEN   = 4'd6;
  localparam logic [3:0] TAG_SVC_BYTE  = 4'd7;
  localparam logic [3:0] TAG_CFG_LEN   = 4'd8;
  localparam logic [3:0] TAG_CFG_BYTE  = 4'd9;
  localparam logic [3:0] TAG_CID_LEN   = 4'd10;
  localparam logic [3:0] TAG_CID_BYTE  = 4'd11;
  localparam logic [3:0] TAG_CFG_SVC   = 4'd12;
  localparam logic [3:0] TAG_RES_LEN   = 4'd13;
  localparam logic [3:0] TAG_RES_BYTE  = 4'd14;
  localparam logic [3:0] TAG_PRIVATE   = 4'd15;

  // Decoder config flag codes that select a config part.
  localparam logic [2:0] CFG_RECORD    = 3'd1;
  localparam logic [2:0] CFG_ID_RECORD = 3'd3;
  localparam logic [2:0] CFG_SVC_ID    = 3'd4;
  localparam logic [2:0] CFG_RES_A     = 3'd5;
  localparam logic [2:0] CFG_RES_B     = 3'd6;

  localparam logic [15:0] APP_FMT_ALL_ONES = 16'hFFFF;
  localparam logic [7:0]  FMT_ALL_ONES     = 8'hFF;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } mdp_in_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [7:0]  byte_value;
    logic [31:0] field_value;
    logic        field_complete;
    logic [2:0]  config_flags;
    logic        dsmcc_present;
    logic        descriptor_done;
    logic        truncated;
  } mdp_out_t;

  // Phase that follows the flags byte or the service id record.
  function automatic phase_t cfg_part_phase(input logic [2:0] flags);
    phase_t ph;
    case (flags)
      CFG_RECORD:         ph = PH_CFGLEN;
      CFG_ID_RECORD:      ph = PH_CIDLEN;
      CFG_SVC_ID:         ph = PH_CFGSVC;
      CFG_RES_A, CFG_RES_B: ph = PH_RESLEN;
      default:            ph = PH_PRIVATE;
    endcase
    return ph;
  endfunction

endpackage

// ===== src/mdp_in_if.sv =====
// Input byte channel: valid/ready with one descriptor payload byte.
interface mdp_in_if import mdp_pkg::*; ();
  logic    valid;
  logic    ready;
  mdp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mdp_out_if.sv =====
// Result channel: valid/ready with one tagged field result.
interface mdp_out_if import mdp_pkg::*; ();
  logic     valid;
  logic     ready;
  mdp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/metadata_descriptor_parser.sv =====
// Metadata descriptor payload parser, one byte per request.
//
// in_req carries one payload byte per request plus final_byte on the last
// byte of a descriptor. out_req returns exactly one result per input byte:
// the field tag, the byte, the assembled field value, completion and flag
// status, descriptor end and a truncation flag.
// Latency: the result is valid in the cycle after the byte is taken.
// Throughput: one byte per cycle; the phase machine and the output register
// update together on each request, so the only limit is the output register.
// When the receiver stalls, the result holds in the output register and
// in_req.ready drops until it is taken (ready = output empty or being read).
// Reset (rst_n low, synchronous) empties the output register and returns the
// phase machine to the application format field. A final byte also returns
// all parse state to its reset values for the next descriptor; a descriptor
// that ends before the private data part is flagged as truncated.
module metadata_descriptor_parser
  import mdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mdp_in_if.sink           in_req,
  mdp_out_if.source        out_req
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;        // bytes taken in current multi-byte field
  logic [7:0]  rec_r, rec_nxt;        // bytes left in current record
  logic [31:0] acc_r, acc_nxt;        // big-endian field accumulator
  logic [2:0]  flags_r, flags_nxt;
  logic        dsmcc_r, dsmcc_nxt;

  logic        out_valid_r;
  mdp_out_t    out_data_r, res;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [31:0] acc_sh;
  logic [7:0]  rec_dec;
  phase_t      next_ph;

  assign in_req.ready = !out_valid_r || out_req.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign b            = in_req.data.payload_byte;
  assign fin          = in_req.data.final_byte;

  // First byte of a field loads, later bytes shift in.
  assign acc_sh  = (bif_r == 2'd0) ? {24'd0, b} : {acc_r[23:0], b};
  assign rec_dec = (rec_r != 8'd0) ? rec_r - 8'd1 : rec_r;

  always_comb begin
    next_ph   = phase_r;
    bif_nxt   = bif_r;
    rec_nxt   = rec_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    dsmcc_nxt = dsmcc_r;
    res       = '0;
    res.byte_value  = b;
    res.field_value = {24'd0, b};

    case (phase_r)
      PH_APPFMT: begin
        res.field_tag   = TAG_APP_FMT;
        acc_nxt         = acc_sh;
        res.field_value = acc_sh;
        if (bif_r == 2'd0) begin
          bif_nxt = 2'd1;
        end else begin
          res.field_complete = 1'b1;
          bif_nxt = 2'd0;
          next_ph = (acc_sh == {16'd0, APP_FMT_ALL_ONES}) ? PH_APPID : PH_FMT;
        end
      end
      PH_APPID, PH_FMTID: begin
        res.field_tag   = (phase_r == PH_APPID) ? TAG_APP_ID : TAG_FMT_ID;
        acc_nxt         = acc_sh;
        res.field_value = acc_sh;
        if (bif_r == 2'd3) begin
          res.field_complete = 1'b1;
          bif_nxt = 2'd0;
          next_ph = (phase_r == PH_APPID) ? PH_FMT : PH_SVCID;
        end else begin
          bif_nxt = bif_r + 2'd1;
        end
      end
      PH_FMT: begin
        res.field_tag      = TAG_FMT;
        res.field_complete = 1'b1;
        next_ph = (b == FMT_ALL_ONES) ? PH_FMTID : PH_SVCID;
      end
      PH_SVCID: begin
        res.field_tag      = TAG_SVC_ID;
        res.field_complete = 1'b1;
        next_ph = PH_FLAGS;
      end
      PH_FLAGS: begin
        res.field_tag      = TAG_FLAGS;
        res.field_complete = 1'b1;
        flags_nxt = b[7:5];
        dsmcc_nxt = b[4];
        next_ph   = b[4] ? PH_SVCLEN : cfg_part_phase(b[7:5]);
      end
      PH_SVCLEN: begin
        res.field_tag      = TAG_SVC_LEN;
        res.field_complete = 1'b1;
        rec_nxt = b;
        next_ph = (b != 8'd0) ? PH_SVCBYTE : cfg_part_phase(flags_r);
      end
      PH_SVCBYTE: begin
        res.field_tag = TAG_SVC_BYTE;
        rec_nxt = rec_dec;
        next_ph = (rec_dec != 8'd0) ? PH_SVCBYTE : cfg_part_phase(flags_r);
      end
      PH_CFGLEN: begin
        res.field_tag      = TAG_CFG_LEN;
        res.field_complete = 1'b1;
        rec_nxt = b;
        next_ph = (b != 8'd0) ? PH_CFGBYTE : PH_PRIVATE;
      end
      PH_CFGBYTE: begin
        res.field_tag = TAG_CFG_BYTE;
        rec_nxt = rec_dec;
        next_ph = (rec_dec != 8'd0) ? PH_CFGBYTE : PH_PRIVATE;
      end
      PH_CIDLEN: begin
        res.field_tag      = TAG_CID_LEN;
        res.field_complete = 1'b1;
        rec_nxt = b;
        next_ph = (b != 8'd0) ? PH_CIDBYTE : PH_PRIVATE;
      end
      PH_CIDBYTE: begin
        res.field_tag = TAG_CID_BYTE;
        rec_nxt = rec_dec;
        next_ph = (rec_dec != 8'd0) ? PH_CIDBYTE : PH_PRIVATE;
      end
      PH_CFGSVC: begin
        res.field_tag      = TAG_CFG_SVC;
        res.field_complete = 1'b1;
        next_ph = PH_PRIVATE;
      end
      PH_RESLEN: begin
        res.field_tag      = TAG_RES_LEN;
        res.field_complete = 1'b1;
        rec_nxt = b;
        next_ph = (b != 8'd0) ? PH_RESBYTE : PH_PRIVATE;
      end
      PH_RESBYTE: begin
        res.field_tag = TAG_RES_BYTE;
        rec_nxt = rec_dec;
        next_ph = (rec_dec != 8'd0) ? PH_RESBYTE : PH_PRIVATE;
      end
      default: begin
        // private data, and any illegal phase code
        res.field_tag = TAG_PRIVATE;
        next_ph = PH_PRIVATE;
      end
    endcase

    res.config_flags    = flags_nxt;
    res.dsmcc_present   = dsmcc_nxt;
    res.descriptor_done = fin;
    res.truncated       = fin && (next_ph != PH_PRIVATE);

    phase_nxt = next_ph;
    // descriptor end: back to reset values
    if (fin) begin
      phase_nxt = PH_APPFMT;
      bif_nxt   = 2'd0;
      rec_nxt   = 8'd0;
      acc_nxt   = 32'd0;
      flags_nxt = 3'd0;
      dsmcc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_APPFMT;
      bif_r       <= 2'd0;
      rec_r       <= 8'd0;
      acc_r       <= 32'd0;
      flags_r     <= 3'd0;
      dsmcc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        bif_r       <= bif_nxt;
        rec_r       <= rec_nxt;
        acc_r       <= acc_nxt;
        flags_r     <= flags_nxt;
        dsmcc_r     <= dsmcc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_req.valid = out_valid_r;
  assign out_req.data  = out_data_r;

endmodule
